// File: rtl/core/rmva_pkg.sv
// ----------------------------------------------------------------------------
// rmva_pkg
// Shared constants for the rotation matrix / vector apply block: register
// map, register widths and reset values, matrix and vector geometry.
// ----------------------------------------------------------------------------
package rmva_pkg;

    // geometry
    localparam int NUM_ELEM = 9;
    localparam int NUM_DIR  = 3;

    // result port width
    localparam int OUT_BITS = 32;

    // configuration registers
    localparam int MO_FIELD_BITS = 4;
    localparam int VO_FIELD_BITS = 2;
    localparam int MO_BITS       = NUM_ELEM * MO_FIELD_BITS;
    localparam int VO_BITS       = NUM_DIR * VO_FIELD_BITS;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 64;

    // register select, taken from paddr[3] (registers sit 8 bytes apart)
    localparam logic REG_MATRIX_ORDER = 1'b0;
    localparam logic REG_VECTOR_ORDER = 1'b1;

    localparam logic [MO_BITS-1:0] MO_RESET = 36'h876543210;
    localparam logic [VO_BITS-1:0] VO_RESET = 6'd36;

endpackage

// File: rtl/core/rotation_matrix_vector_apply.sv
// ----------------------------------------------------------------------------
// rotation_matrix_vector_apply
// Applies a 3x3 fixed-point rotation matrix to a 3-component integer vector.
// Storage slots are mapped to canonical elements by two permutation
// registers; each row sum is rounded half up and saturated.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | in_valid / in_stall | m_slot0..m_slot8, v_slot0..2
//  out     | output    | out_valid/out_stall | out_x, out_y, out_z, overflow
//  cfg     | input     | APB psel / penable  | paddr, pwdata, prdata
//
//  One request accepted per cycle while in_stall is low; out_valid is
//  registered after the permute, product and round/saturate registers.
//  Each of the nine products is cut in two partial products, so that no
//  multiplier exceeds MATRIX_BITS x (VECTOR_BITS/2 + 1).
//  rst_n clears all valid flags and loads the permutation reset values.
//  in_stall rises only when all three stages are full and out_stall is high.
//
module rotation_matrix_vector_apply #(
    parameter int MATRIX_BITS = 16,
    parameter int FRAC_BITS   = 14,
    parameter int VECTOR_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [MATRIX_BITS-1:0]          m_slot0,
    input  logic signed [MATRIX_BITS-1:0]          m_slot1,
    input  logic signed [MATRIX_BITS-1:0]          m_slot2,
    input  logic signed [MATRIX_BITS-1:0]          m_slot3,
    input  logic signed [MATRIX_BITS-1:0]          m_slot4,
    input  logic signed [MATRIX_BITS-1:0]          m_slot5,
    input  logic signed [MATRIX_BITS-1:0]          m_slot6,
    input  logic signed [MATRIX_BITS-1:0]          m_slot7,
    input  logic signed [MATRIX_BITS-1:0]          m_slot8,
    input  logic signed [VECTOR_BITS-1:0]          v_slot0,
    input  logic signed [VECTOR_BITS-1:0]          v_slot1,
    input  logic signed [VECTOR_BITS-1:0]          v_slot2,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [rmva_pkg::OUT_BITS-1:0]   out_x,
    output logic signed [rmva_pkg::OUT_BITS-1:0]   out_y,
    output logic signed [rmva_pkg::OUT_BITS-1:0]   out_z,
    output logic                                   overflow,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rmva_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [rmva_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [rmva_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    localparam int RES_BITS  = (VECTOR_BITS < 32) ? VECTOR_BITS : 32;
    localparam int LO_BITS   = VECTOR_BITS / 2;
    localparam int HI_BITS   = VECTOR_BITS - LO_BITS;
    localparam int PH_BITS   = MATRIX_BITS + HI_BITS;
    localparam int PL_BITS   = MATRIX_BITS + LO_BITS + 1;
    localparam int SUM_A     = MATRIX_BITS + VECTOR_BITS + 2;
    localparam int SUM_BITS  = (SUM_A > FRAC_BITS + 2) ? SUM_A : FRAC_BITS + 2;
    localparam int TOP_BITS  = SUM_BITS - RES_BITS + 1;

    localparam logic [SUM_BITS-1:0] HALF =
        {{(SUM_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [rmva_pkg::MO_BITS-1:0] matrix_order_reg;
    logic [rmva_pkg::VO_BITS-1:0] vector_order_reg;
    logic                         cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_order_reg <= rmva_pkg::MO_RESET;
            vector_order_reg <= rmva_pkg::VO_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3])
                rmva_pkg::REG_MATRIX_ORDER:
                    matrix_order_reg <= pwdata[rmva_pkg::MO_BITS-1:0];
                rmva_pkg::REG_VECTOR_ORDER:
                    vector_order_reg <= pwdata[rmva_pkg::VO_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            rmva_pkg::REG_MATRIX_ORDER:
                prdata = rmva_pkg::APB_DATA_BITS'(matrix_order_reg);
            rmva_pkg::REG_VECTOR_ORDER:
                prdata = rmva_pkg::APB_DATA_BITS'(vector_order_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic en_out, en2, en1;

    assign en_out   = !out_valid_reg || !out_stall;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: slot to canonical permutation
    // ------------------------------------------------------------------
    logic signed [MATRIX_BITS-1:0] m_in     [rmva_pkg::NUM_ELEM];
    logic signed [VECTOR_BITS-1:0] v_in     [rmva_pkg::NUM_DIR];
    logic signed [MATRIX_BITS-1:0] mat_next [rmva_pkg::NUM_ELEM];
    logic signed [VECTOR_BITS-1:0] vec_next [rmva_pkg::NUM_DIR];
    logic signed [MATRIX_BITS-1:0] s1_mat_reg [rmva_pkg::NUM_ELEM];
    logic signed [VECTOR_BITS-1:0] s1_vec_reg [rmva_pkg::NUM_DIR];

    assign m_in[0] = m_slot0;
    assign m_in[1] = m_slot1;
    assign m_in[2] = m_slot2;
    assign m_in[3] = m_slot3;
    assign m_in[4] = m_slot4;
    assign m_in[5] = m_slot5;
    assign m_in[6] = m_slot6;
    assign m_in[7] = m_slot7;
    assign m_in[8] = m_slot8;
    assign v_in[0] = v_slot0;
    assign v_in[1] = v_slot1;
    assign v_in[2] = v_slot2;

    // later slot wins on a duplicate target; unnamed targets read zero
    always_comb
    begin
        for (int k = 0; k < rmva_pkg::NUM_ELEM; k++)
        begin
            mat_next[k] = '0;
            for (int i = 0; i < rmva_pkg::NUM_ELEM; i++)
            begin
                if (matrix_order_reg[i*rmva_pkg::MO_FIELD_BITS +: rmva_pkg::MO_FIELD_BITS]
                    == rmva_pkg::MO_FIELD_BITS'(k))
                    mat_next[k] = m_in[i];
            end
        end
        for (int k = 0; k < rmva_pkg::NUM_DIR; k++)
        begin
            vec_next[k] = '0;
            for (int i = 0; i < rmva_pkg::NUM_DIR; i++)
            begin
                if (vector_order_reg[i*rmva_pkg::VO_FIELD_BITS +: rmva_pkg::VO_FIELD_BITS]
                    == rmva_pkg::VO_FIELD_BITS'(k))
                    vec_next[k] = v_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_mat_reg <= mat_next;
            s1_vec_reg <= vec_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: partial products, vector split into high and low halves
    // ------------------------------------------------------------------
    logic signed [PH_BITS-1:0] ph_next   [rmva_pkg::NUM_ELEM];
    logic signed [PL_BITS-1:0] pl_next   [rmva_pkg::NUM_ELEM];
    logic signed [PH_BITS-1:0] s2_ph_reg [rmva_pkg::NUM_ELEM];
    logic signed [PL_BITS-1:0] s2_pl_reg [rmva_pkg::NUM_ELEM];
    logic signed [HI_BITS-1:0] vh        [rmva_pkg::NUM_DIR];
    logic signed [LO_BITS:0]   vl        [rmva_pkg::NUM_DIR];

    always_comb
    begin
        for (int c = 0; c < rmva_pkg::NUM_DIR; c++)
        begin
            vh[c] = s1_vec_reg[c][VECTOR_BITS-1:LO_BITS];
            vl[c] = $signed({1'b0, s1_vec_reg[c][LO_BITS-1:0]});
        end
        for (int k = 0; k < rmva_pkg::NUM_ELEM; k++)
        begin
            ph_next[k] = s1_mat_reg[k] * vh[k % rmva_pkg::NUM_DIR];
            pl_next[k] = s1_mat_reg[k] * vl[k % rmva_pkg::NUM_DIR];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_ph_reg <= ph_next;
            s2_pl_reg <= pl_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: row sums, round half up, saturate
    // ------------------------------------------------------------------
    logic signed [SUM_BITS-1:0]          acc     [rmva_pkg::NUM_DIR];
    logic signed [SUM_BITS-1:0]          shifted [rmva_pkg::NUM_DIR];
    logic        [TOP_BITS-1:0]          top     [rmva_pkg::NUM_DIR];
    logic signed [RES_BITS-1:0]          res     [rmva_pkg::NUM_DIR];
    logic        [rmva_pkg::NUM_DIR-1:0] ovf;

    logic signed [rmva_pkg::OUT_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                                 overflow_reg;

    always_comb
    begin
        for (int r = 0; r < rmva_pkg::NUM_DIR; r++)
        begin
            acc[r] = $signed(HALF);
            for (int c = 0; c < rmva_pkg::NUM_DIR; c++)
            begin
                acc[r] = acc[r]
                       + (SUM_BITS'(s2_ph_reg[rmva_pkg::NUM_DIR*r + c]) <<< LO_BITS)
                       + SUM_BITS'(s2_pl_reg[rmva_pkg::NUM_DIR*r + c]);
            end
            shifted[r] = acc[r] >>> FRAC_BITS;
            top[r]     = shifted[r][SUM_BITS-1:RES_BITS-1];
            ovf[r]     = !((&top[r]) || !(|top[r]));
            if (ovf[r])
                res[r] = $signed({shifted[r][SUM_BITS-1],
                                  {(RES_BITS-1){~shifted[r][SUM_BITS-1]}}});
            else
                res[r] = shifted[r][RES_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s2_valid_reg)
        begin
            out_x_reg    <= rmva_pkg::OUT_BITS'(res[0]);
            out_y_reg    <= rmva_pkg::OUT_BITS'(res[1]);
            out_z_reg    <= rmva_pkg::OUT_BITS'(res[2]);
            overflow_reg <= |ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign overflow  = overflow_reg;

`ifndef SYNTH
    // back-pressure only when every stage holds a request
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("in_stall raised with a free pipeline stage");

    // an accepted request lands in stage 1
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted request lost at stage 1");

    // stage 1 content moves on to stage 2 when it advances
    a_s1_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && en2) |=> s2_valid_reg)
        else $error("request lost between stage 1 and stage 2");

    // a result leaves only when taken; a held result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_x_reg)
                                          && $stable(overflow_reg)))
        else $error("stalled result dropped or changed");

    // matrix_order write takes the low bits of the write data
    a_cfg_mo: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[3] == rmva_pkg::REG_MATRIX_ORDER) |=>
            (matrix_order_reg == $past(pwdata[rmva_pkg::MO_BITS-1:0])))
        else $error("matrix_order write not applied");
`endif

endmodule

// File: tb/sv/rotation_matrix_vector_apply_checker.sv
// ----------------------------------------------------------------------------
// rotation_matrix_vector_apply_checker
// Passive scoreboard for the rotation block. It follows register writes on the
// APB port, works out the rotated vector for every accepted request and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_vector_apply_checker #(
    parameter int MATRIX_BITS = 16,
    parameter int FRAC_BITS   = 14,
    parameter int VECTOR_BITS = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,

    input  logic                                          in_valid,
    input  logic                                          in_stall,
    input  logic [rmva_pkg::NUM_ELEM*MATRIX_BITS-1:0]     m_bus,
    input  logic [rmva_pkg::NUM_DIR*VECTOR_BITS-1:0]      v_bus,

    input  logic                                          out_valid,
    input  logic                                          out_stall,
    input  logic signed [rmva_pkg::OUT_BITS-1:0]          out_x,
    input  logic signed [rmva_pkg::OUT_BITS-1:0]          out_y,
    input  logic signed [rmva_pkg::OUT_BITS-1:0]          out_z,
    input  logic                                          overflow,

    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic                                          pready,
    input  logic [rmva_pkg::APB_ADDR_BITS-1:0]            paddr,
    input  logic [rmva_pkg::APB_DATA_BITS-1:0]            pwdata,

    output int                                            mismatches,
    output int                                            outstanding,
    output int                                            checked,
    output int                                            saturated
);

    localparam int     RES_BITS = (VECTOR_BITS < rmva_pkg::OUT_BITS)
                                  ? VECTOR_BITS : rmva_pkg::OUT_BITS;
    localparam longint RES_MAX  = (longint'(1) << (RES_BITS - 1)) - 1;
    localparam longint RES_MIN  = -RES_MAX - 1;
    localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [rmva_pkg::OUT_BITS-1:0] x;
        logic signed [rmva_pkg::OUT_BITS-1:0] y;
        logic signed [rmva_pkg::OUT_BITS-1:0] z;
        logic                                 ovf;
    } rotated_t;

    rotated_t                         rotated_pending[$];
    logic [rmva_pkg::MO_BITS-1:0]     matrix_map;
    logic [rmva_pkg::VO_BITS-1:0]     vector_map;

    function automatic rotated_t rotate_vector(
        input logic [rmva_pkg::NUM_ELEM*MATRIX_BITS-1:0] m,
        input logic [rmva_pkg::NUM_DIR*VECTOR_BITS-1:0]  v,
        input logic [rmva_pkg::MO_BITS-1:0]              mo,
        input logic [rmva_pkg::VO_BITS-1:0]              vo
    );
        longint                              elem [rmva_pkg::NUM_ELEM];
        longint                              comp [rmva_pkg::NUM_DIR];
        longint                              row_sum [rmva_pkg::NUM_DIR];
        logic [rmva_pkg::MO_FIELD_BITS-1:0]  m_tgt;
        logic [rmva_pkg::VO_FIELD_BITS-1:0]  v_tgt;
        rotated_t                            r;
        r.ovf = 1'b0;
        foreach (elem[i]) elem[i] = 0;
        foreach (comp[i]) comp[i] = 0;
        // slots are walked upward, so a later slot naming the same target wins;
        // out-of-range fields drop their slot, unnamed targets stay zero
        for (int i = 0; i < rmva_pkg::NUM_ELEM; i++)
        begin
            m_tgt = mo[rmva_pkg::MO_FIELD_BITS*i +: rmva_pkg::MO_FIELD_BITS];
            if (m_tgt < rmva_pkg::NUM_ELEM)
                elem[m_tgt] = $signed(m[MATRIX_BITS*i +: MATRIX_BITS]);
        end
        for (int i = 0; i < rmva_pkg::NUM_DIR; i++)
        begin
            v_tgt = vo[rmva_pkg::VO_FIELD_BITS*i +: rmva_pkg::VO_FIELD_BITS];
            if (v_tgt < rmva_pkg::NUM_DIR)
                comp[v_tgt] = $signed(v[VECTOR_BITS*i +: VECTOR_BITS]);
        end
        for (int row = 0; row < rmva_pkg::NUM_DIR; row++)
        begin
            // exact sum plus half an LSB, then floor
            row_sum[row] = HALF_LSB;
            for (int col = 0; col < rmva_pkg::NUM_DIR; col++)
                row_sum[row] += elem[rmva_pkg::NUM_DIR*row + col] * comp[col];
            row_sum[row] = row_sum[row] >>> FRAC_BITS;
            if (row_sum[row] > RES_MAX)
            begin
                row_sum[row] = RES_MAX;
                r.ovf = 1'b1;
            end
            else if (row_sum[row] < RES_MIN)
            begin
                row_sum[row] = RES_MIN;
                r.ovf = 1'b1;
            end
        end
        r.x = rmva_pkg::OUT_BITS'(row_sum[0]);
        r.y = rmva_pkg::OUT_BITS'(row_sum[1]);
        r.z = rmva_pkg::OUT_BITS'(row_sum[2]);
        return r;
    endfunction

    function automatic int field_differs(
        input string                                name,
        input logic signed [rmva_pkg::OUT_BITS-1:0] want,
        input logic signed [rmva_pkg::OUT_BITS-1:0] got
    );
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        rotated_t want;
        int       errs;
        if (!rst_n)
        begin
            rotated_pending.delete();
            matrix_map  <= rmva_pkg::MO_RESET;
            vector_map  <= rmva_pkg::VO_RESET;
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
            saturated   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (rotated_pending.size() == 0)
                begin
                    $display("%0t: result (%0d, %0d, %0d, overflow %0b) with nothing pending",
                             $time, out_x, out_y, out_z, overflow);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = rotated_pending.pop_front();
                    errs = field_differs("out_x", want.x, out_x)
                         + field_differs("out_y", want.y, out_y)
                         + field_differs("out_z", want.z, out_z)
                         + field_differs("overflow", want.ovf, overflow);
                    mismatches <= mismatches + errs;
                    checked    <= checked + 1;
                    saturated  <= saturated + want.ovf;
                end
            end
            if (in_valid && !in_stall)
                rotated_pending.push_back(rotate_vector(m_bus, v_bus, matrix_map, vector_map));
            outstanding <= rotated_pending.size();
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3])
                    rmva_pkg::REG_MATRIX_ORDER:
                        matrix_map <= pwdata[rmva_pkg::MO_BITS-1:0];
                    rmva_pkg::REG_VECTOR_ORDER:
                        vector_map <= pwdata[rmva_pkg::VO_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: tb/sv/rotation_matrix_vector_apply_tb.sv
// ----------------------------------------------------------------------------
// rotation_matrix_vector_apply_tb
// Drives the rotation block with corner and random requests under a series of
// slot mappings (identity, reversed, duplicate, unnamed, shuffled, random),
// with random gaps and output stalls, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_vector_apply_tb;

    localparam int MATRIX_BITS        = 16;
    localparam int FRAC_BITS          = 14;
    localparam int VECTOR_BITS        = 32;
    localparam int IDLE_LIMIT         = 2000;
    localparam int HOLD_CYCLES        = 200;
    localparam int NUM_SETTINGS       = 11;
    localparam int RANDOM_PER_SETTING = 165;

    localparam logic [MATRIX_BITS-1:0] ELEM_MAX  = {1'b0, {(MATRIX_BITS-1){1'b1}}};
    localparam logic [MATRIX_BITS-1:0] ELEM_MIN  = {1'b1, {(MATRIX_BITS-1){1'b0}}};
    localparam logic [MATRIX_BITS-1:0] ELEM_ONE  = MATRIX_BITS'(1) << FRAC_BITS;
    localparam logic [VECTOR_BITS-1:0] COMP_MAX  = {1'b0, {(VECTOR_BITS-1){1'b1}}};
    localparam logic [VECTOR_BITS-1:0] COMP_MIN  = {1'b1, {(VECTOR_BITS-1){1'b0}}};
    localparam logic [VECTOR_BITS-1:0] COMP_HALF = VECTOR_BITS'(1) << (FRAC_BITS - 1);

    logic                                       clk       = 1'b0;
    logic                                       rst_n     = 1'b0;
    logic                                       in_valid  = 1'b0;
    logic                                       out_stall = 1'b0;
    logic [rmva_pkg::NUM_ELEM*MATRIX_BITS-1:0]  m_bus     = '0;
    logic [rmva_pkg::NUM_DIR*VECTOR_BITS-1:0]   v_bus     = '0;
    logic                                       psel      = 1'b0;
    logic                                       penable   = 1'b0;
    logic                                       pwrite    = 1'b0;
    logic [rmva_pkg::APB_ADDR_BITS-1:0]         paddr     = '0;
    logic [rmva_pkg::APB_DATA_BITS-1:0]         pwdata    = '0;

    logic                                       in_stall;
    logic                                       out_valid;
    logic signed [rmva_pkg::OUT_BITS-1:0]       out_x;
    logic signed [rmva_pkg::OUT_BITS-1:0]       out_y;
    logic signed [rmva_pkg::OUT_BITS-1:0]       out_z;
    logic                                       overflow;
    logic [rmva_pkg::APB_DATA_BITS-1:0]         prdata;
    logic                                       pready;

    int mismatches;
    int outstanding;
    int checked;
    int saturated;
    int requests_sent = 0;
    int idle_cycles   = 0;
    bit tx_gaps       = 1'b1;
    bit rx_gaps       = 1'b1;
    bit hold_req      = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rotation_matrix_vector_apply #(
        .MATRIX_BITS (MATRIX_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .VECTOR_BITS (VECTOR_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .m_slot0   (m_bus[0*MATRIX_BITS +: MATRIX_BITS]),
        .m_slot1   (m_bus[1*MATRIX_BITS +: MATRIX_BITS]),
        .m_slot2   (m_bus[2*MATRIX_BITS +: MATRIX_BITS]),
        .m_slot3   (m_bus[3*MATRIX_BITS +: MATRIX_BITS]),
        .m_slot4   (m_bus[4*MATRIX_BITS +: MATRIX_BITS]),
        .m_slot5   (m_bus[5*MATRIX_BITS +: MATRIX_BITS]),
        .m_slot6   (m_bus[6*MATRIX_BITS +: MATRIX_BITS]),
        .m_slot7   (m_bus[7*MATRIX_BITS +: MATRIX_BITS]),
        .m_slot8   (m_bus[8*MATRIX_BITS +: MATRIX_BITS]),
        .v_slot0   (v_bus[0*VECTOR_BITS +: VECTOR_BITS]),
        .v_slot1   (v_bus[1*VECTOR_BITS +: VECTOR_BITS]),
        .v_slot2   (v_bus[2*VECTOR_BITS +: VECTOR_BITS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .overflow  (overflow),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    rotation_matrix_vector_apply_checker #(
        .MATRIX_BITS (MATRIX_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .VECTOR_BITS (VECTOR_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .m_bus       (m_bus),
        .v_bus       (v_bus),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .overflow    (overflow),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .saturated   (saturated)
    );

    function automatic logic [MATRIX_BITS-1:0] rand_elem(input int style);
        case (style)
            0: return MATRIX_BITS'($urandom_range(0, 2*ELEM_ONE) - ELEM_ONE); // |a| <= 1.0
            1:
            begin
                case ($urandom_range(0, 6))
                    0: return '0;
                    1: return MATRIX_BITS'(1);
                    2: return MATRIX_BITS'(-1);
                    3: return ELEM_ONE;
                    4: return -ELEM_ONE;
                    5: return ELEM_MAX;
                    default: return ELEM_MIN;
                endcase
            end
            default: return MATRIX_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [VECTOR_BITS-1:0] rand_comp(input int style);
        case (style)
            1:
            begin
                case ($urandom_range(0, 6))
                    0: return '0;
                    1: return VECTOR_BITS'(1);
                    2: return VECTOR_BITS'(-1);
                    3: return COMP_MAX;
                    4: return COMP_MIN;
                    5: return COMP_HALF;
                    default: return -COMP_HALF;
                endcase
            end
            2: return VECTOR_BITS'($urandom_range(0, 200000) - 100000);
            default: return VECTOR_BITS'({$urandom, $urandom});
        endcase
    endfunction

    // style 3 mixes the per-field styles within one request
    function automatic logic [rmva_pkg::NUM_ELEM*MATRIX_BITS-1:0] random_matrix();
        logic [rmva_pkg::NUM_ELEM*MATRIX_BITS-1:0] m;
        int                                        style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < rmva_pkg::NUM_ELEM; i++)
            m[MATRIX_BITS*i +: MATRIX_BITS] = rand_elem(style == 3 ? $urandom_range(0, 2) : style);
        return m;
    endfunction

    function automatic logic [rmva_pkg::NUM_DIR*VECTOR_BITS-1:0] random_vector();
        logic [rmva_pkg::NUM_DIR*VECTOR_BITS-1:0] v;
        int                                       style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < rmva_pkg::NUM_DIR; i++)
            v[VECTOR_BITS*i +: VECTOR_BITS] = rand_comp(style == 3 ? $urandom_range(0, 2) : style);
        return v;
    endfunction

    function automatic logic [rmva_pkg::NUM_ELEM*MATRIX_BITS-1:0] matrix_diag(
        input logic [MATRIX_BITS-1:0] d
    );
        logic [rmva_pkg::NUM_ELEM*MATRIX_BITS-1:0] m;
        m = '0;
        m[0*MATRIX_BITS +: MATRIX_BITS] = d;
        m[4*MATRIX_BITS +: MATRIX_BITS] = d;
        m[8*MATRIX_BITS +: MATRIX_BITS] = d;
        return m;
    endfunction

    function automatic logic [rmva_pkg::NUM_DIR*VECTOR_BITS-1:0] vec3(
        input logic [VECTOR_BITS-1:0] a,
        input logic [VECTOR_BITS-1:0] b,
        input logic [VECTOR_BITS-1:0] c
    );
        return {c, b, a};
    endfunction

    task automatic offer_vector(
        input logic [rmva_pkg::NUM_ELEM*MATRIX_BITS-1:0] m,
        input logic [rmva_pkg::NUM_DIR*VECTOR_BITS-1:0]  v
    );
        int gap;
        in_valid <= 1'b1;
        m_bus    <= m;
        v_bus    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        gap = 0;
        if (tx_gaps && $urandom_range(0, 99) < 30)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic apb_write_reg(input logic sel,
                                 input logic [rmva_pkg::APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // output side: short random stalls, a few long ones, one long hold on request
    initial
    begin : result_sink
        int run;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 99) < 20)
            begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: nothing moved for %0d cycles", $time, IDLE_LIMIT);
        $display("rotation_matrix_vector_apply: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        logic [rmva_pkg::MO_BITS-1:0] mo;
        logic [rmva_pkg::VO_BITS-1:0] vo;
        int                           perm [rmva_pkg::NUM_ELEM];
        int                           j;
        int                           tmp;
        int                           d0;
        int                           d1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners under the reset mapping: slot i holds element i, slots 0..2 hold x, y, z
        offer_vector('0, vec3(COMP_MAX, COMP_MIN, VECTOR_BITS'(-1)));
        offer_vector(matrix_diag(ELEM_ONE), vec3(COMP_MAX, COMP_MIN, VECTOR_BITS'(1)));
        offer_vector(matrix_diag(-ELEM_ONE),
                     vec3(VECTOR_BITS'(-1), '0, VECTOR_BITS'(123456789)));
        offer_vector({rmva_pkg::NUM_ELEM{ELEM_MIN}}, {rmva_pkg::NUM_DIR{COMP_MIN}});
        offer_vector({rmva_pkg::NUM_ELEM{ELEM_MAX}}, {rmva_pkg::NUM_DIR{COMP_MIN}});
        offer_vector({rmva_pkg::NUM_ELEM{ELEM_MIN}}, {rmva_pkg::NUM_DIR{COMP_MAX}});
        offer_vector({rmva_pkg::NUM_ELEM{ELEM_MAX}}, {rmva_pkg::NUM_DIR{COMP_MAX}});
        // rounding ties go up
        offer_vector(matrix_diag(MATRIX_BITS'(1)),
                     vec3(COMP_HALF, -COMP_HALF, COMP_HALF - 1));
        offer_vector(matrix_diag(MATRIX_BITS'(1)),
                     vec3(-COMP_HALF - 1, 3*COMP_HALF, -3*COMP_HALF));
        // only the x row saturates; then no row does (each row rounds to -1 LSB)
        offer_vector({{(6*MATRIX_BITS){1'b0}}, {3{ELEM_MAX}}}, {rmva_pkg::NUM_DIR{COMP_MAX}});
        offer_vector({(rmva_pkg::NUM_ELEM*MATRIX_BITS){1'b1}}, vec3(COMP_HALF + 1, '0, '0));
        // -2.0 scaling: exact minimum on x, one past maximum on y
        offer_vector(matrix_diag(ELEM_MIN), vec3(32'h4000_0000, 32'hC000_0000, 32'h3FFF_FFFF));

        repeat (RANDOM_PER_SETTING) offer_vector(random_matrix(), random_vector());

        // keep offering through a long output hold so the pipe fills and stalls
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (30) offer_vector(random_matrix(), random_vector());
        while (hold_req)
            @(posedge clk);
        tx_gaps = 1'b1;

        for (int s = 1; s < NUM_SETTINGS; s++)
        begin
            wait_results_drained();
            case (s)
                1:
                begin
                    mo = 36'h012345678;
                    vo = 6'b00_01_10;
                end
                2:
                begin
                    // every slot names xx / x: highest slot wins
                    mo = '0;
                    vo = '0;
                end
                3:
                begin
                    // nothing named: all-zero matrix and vector
                    mo = '1;
                    vo = '1;
                end
                4, 9:
                begin
                    for (int i = 0; i < rmva_pkg::NUM_ELEM; i++)
                        perm[i] = i;
                    for (int i = rmva_pkg::NUM_ELEM - 1; i > 0; i--)
                    begin
                        j       = $urandom_range(0, i);
                        tmp     = perm[i];
                        perm[i] = perm[j];
                        perm[j] = tmp;
                    end
                    for (int i = 0; i < rmva_pkg::NUM_ELEM; i++)
                        mo[rmva_pkg::MO_FIELD_BITS*i +: rmva_pkg::MO_FIELD_BITS] =
                            rmva_pkg::MO_FIELD_BITS'(perm[i]);
                    d0 = $urandom_range(0, 2);
                    d1 = (d0 + 1 + $urandom_range(0, 1)) % 3;
                    vo = {rmva_pkg::VO_FIELD_BITS'(3 - d0 - d1),
                          rmva_pkg::VO_FIELD_BITS'(d1),
                          rmva_pkg::VO_FIELD_BITS'(d0)};
                end
                NUM_SETTINGS - 1:
                begin
                    mo = rmva_pkg::MO_RESET;
                    vo = rmva_pkg::VO_RESET;
                end
                default:
                begin
                    // mostly valid targets, with duplicates and out-of-range fields mixed in
                    for (int i = 0; i < rmva_pkg::NUM_ELEM; i++)
                        mo[rmva_pkg::MO_FIELD_BITS*i +: rmva_pkg::MO_FIELD_BITS] =
                            ($urandom_range(0, 99) < 75)
                            ? rmva_pkg::MO_FIELD_BITS'($urandom_range(0, rmva_pkg::NUM_ELEM - 1))
                            : rmva_pkg::MO_FIELD_BITS'($urandom_range(rmva_pkg::NUM_ELEM, 15));
                    vo = rmva_pkg::VO_BITS'($urandom);
                end
            endcase
            apb_write_reg(rmva_pkg::REG_MATRIX_ORDER, rmva_pkg::APB_DATA_BITS'(mo));
            apb_write_reg(rmva_pkg::REG_VECTOR_ORDER, rmva_pkg::APB_DATA_BITS'(vo));
            // every third setting runs with neither side idling
            tx_gaps = (s % 3 != 2);
            rx_gaps = tx_gaps;
            repeat (RANDOM_PER_SETTING) offer_vector(random_matrix(), random_vector());
        end

        wait_results_drained();
        repeat (8) @(posedge clk);

        $display("%0d requests over %0d slot mappings; %0d results checked, %0d saturated",
                 requests_sent, NUM_SETTINGS, checked, saturated);
        if (mismatches == 0)
            $display("rotation_matrix_vector_apply: match");
        else
            $display("rotation_matrix_vector_apply: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rmva_pkg.sv
rtl/core/rotation_matrix_vector_apply.sv
tb/sv/rotation_matrix_vector_apply_checker.sv
tb/sv/rotation_matrix_vector_apply_tb.sv
